// File: rtl/pvsa_pkg.sv
// ----------------------------------------------------------------------------
// pvsa_pkg: shared types for the priority voice slot allocator
// Beat payloads, the command that all cells see, the carry that moves along
// the cell chain and the commit strobe for a granted play.
// ----------------------------------------------------------------------------
package pvsa_pkg;

    // Wide enough to hold every slot position and the "no slot" code.
    localparam int IDX_W = 9;

    typedef enum logic [2:0] {
        MODE_PLAY     = 3'd0,
        MODE_STOP     = 3'd1,
        MODE_QUERY    = 3'd2,
        MODE_SET_VOL  = 3'd3,
        MODE_READ_VOL = 3'd4,
        MODE_SET_RATE = 3'd5,
        MODE_READ_RATE = 3'd6,
        MODE_END      = 3'd7
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [4:0]         slot_index;
        logic [15:0]        id_version;
        logic [7:0]         buffer_id;
        logic signed [15:0] priority_req;
        logic [15:0]        volume_value;
        logic [15:0]        rate_value;
        logic               loop_flag;
    } in_beat_t;

    typedef struct packed {
        logic        ok;
        logic [4:0]  result_slot;
        logic [15:0] result_version;
        logic [15:0] read_value;
        logic        stole_voice;
    } out_beat_t;

    typedef struct packed {
        in_beat_t         beat;
        logic             idx_ok;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic               valid;
        logic               found_free;
        logic               have_pick;
        logic signed [15:0] lowest;
        logic [IDX_W-1:0]   pick;
        logic [15:0]        pick_ver;
        logic               ok;
        logic [15:0]        rval;
    } carry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } commit_t;

endpackage

// File: rtl/pvsa_cell.sv
// ----------------------------------------------------------------------------
// pvsa_cell: one voice slot of the allocator chain
// Holds the state of a single slot, applies voice id operations that address
// it and folds its own entry into the play scan carry before passing it on.
// ----------------------------------------------------------------------------
module pvsa_cell #(
    parameter int CELL_POS = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pvsa_pkg::cmd_t    cmd,
    input  pvsa_pkg::commit_t commit,
    input  pvsa_pkg::carry_t  carry_in,
    output pvsa_pkg::carry_t  carry_out
);

    localparam logic [pvsa_pkg::IDX_W-1:0] MY_POS = CELL_POS[pvsa_pkg::IDX_W-1:0];

    logic               active_reg, active_next;
    logic [15:0]        version_reg, version_next;
    logic signed [15:0] prio_reg, prio_next;
    logic [15:0]        volume_reg, volume_next;
    logic [15:0]        rate_reg, rate_next;
    logic               loops_reg, loops_next;
    logic [7:0]         buffer_reg, buffer_next;
    pvsa_pkg::carry_t   carry_reg, carry_next;
    logic               hit;
    logic               id_match;

    assign hit      = carry_in.valid && cmd.idx_ok && (cmd.idx == MY_POS);
    assign id_match = hit && active_reg && (version_reg == cmd.beat.id_version);

    always_comb begin
        active_next  = active_reg;
        version_next = version_reg;
        prio_next    = prio_reg;
        volume_next  = volume_reg;
        rate_next    = rate_reg;
        loops_next   = loops_reg;
        buffer_next  = buffer_reg;
        carry_next   = carry_in;

        if (commit.en && (commit.idx == MY_POS)) begin
            active_next  = 1'b1;
            version_next = version_reg + 16'd1;
            prio_next    = cmd.beat.priority_req;
            volume_next  = cmd.beat.volume_value;
            rate_next    = cmd.beat.rate_value;
            loops_next   = cmd.beat.loop_flag;
            buffer_next  = cmd.beat.buffer_id;
        end else if (carry_in.valid) begin
            unique case (cmd.beat.mode)
                pvsa_pkg::MODE_PLAY: begin
                    if (!carry_in.found_free) begin
                        if (!active_reg) begin
                            carry_next.found_free = 1'b1;
                            carry_next.have_pick  = 1'b1;
                            carry_next.pick       = MY_POS;
                            carry_next.pick_ver   = version_reg;
                        end else if (prio_reg < carry_in.lowest) begin
                            carry_next.lowest    = prio_reg;
                            carry_next.have_pick = 1'b1;
                            carry_next.pick      = MY_POS;
                            carry_next.pick_ver  = version_reg;
                        end
                    end
                end
                pvsa_pkg::MODE_END: begin
                    if (hit && active_reg && !loops_reg) begin
                        active_next   = 1'b0;
                        carry_next.ok = 1'b1;
                    end
                end
                pvsa_pkg::MODE_STOP: begin
                    if (id_match) begin
                        active_next   = 1'b0;
                        carry_next.ok = 1'b1;
                    end
                end
                pvsa_pkg::MODE_QUERY: begin
                    if (id_match) begin
                        carry_next.ok = 1'b1;
                    end
                end
                pvsa_pkg::MODE_SET_VOL: begin
                    if (id_match) begin
                        volume_next   = cmd.beat.volume_value;
                        carry_next.ok = 1'b1;
                    end
                end
                pvsa_pkg::MODE_READ_VOL: begin
                    if (id_match) begin
                        carry_next.rval = volume_reg;
                        carry_next.ok   = 1'b1;
                    end
                end
                pvsa_pkg::MODE_SET_RATE: begin
                    if (id_match) begin
                        rate_next     = cmd.beat.rate_value;
                        carry_next.ok = 1'b1;
                    end
                end
                pvsa_pkg::MODE_READ_RATE: begin
                    if (id_match) begin
                        carry_next.rval = rate_reg;
                        carry_next.ok   = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg      <= 1'b0;
            version_reg     <= 16'd0;
            carry_reg.valid <= 1'b0;
        end else begin
            active_reg  <= active_next;
            version_reg <= version_next;
            carry_reg   <= carry_next;
        end
    end

    always_ff @(posedge aclk) begin
        prio_reg   <= prio_next;
        volume_reg <= volume_next;
        rate_reg   <= rate_next;
        loops_reg  <= loops_next;
        buffer_reg <= buffer_next;
    end

    assign carry_out = carry_reg;

endmodule

// File: rtl/priority_voice_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// priority_voice_slot_allocator_core: voice slot table with priority stealing
// Allocates, addresses and frees voice slots through versioned voice ids.
// ----------------------------------------------------------------------------
// One beat is processed at a time. A carry walks through the row of SLOTS
// slot cells, one cell per cycle; a register captures the end of the walk,
// and once the output register is free the result beat is formed and, for a
// granted play, the chosen slot is loaded. s_ready is high while no beat is
// in progress, even when the previous result is still waiting on m_ready.
// After reset the block is ready at once.
module priority_voice_slot_allocator_core #(
    parameter int SLOTS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pvsa_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pvsa_pkg::out_beat_t m_data
);

    localparam int IW = pvsa_pkg::IDX_W;
    localparam logic [IW-1:0] NO_SLOT = SLOTS[IW-1:0];

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t              state_reg;
    pvsa_pkg::cmd_t      cmd_reg;
    logic                launch_reg;
    pvsa_pkg::carry_t    res_reg;
    logic                m_valid_reg;
    pvsa_pkg::out_beat_t m_data_reg;
    pvsa_pkg::out_beat_t result;
    pvsa_pkg::commit_t   commit;
    pvsa_pkg::carry_t    chain [SLOTS+1];
    logic                accept;
    logic                out_free;
    logic [IW-1:0]       idx_ext;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign idx_ext  = IW'(s_data.slot_index);

    always_comb begin
        chain[0]            = '0;
        chain[0].valid      = launch_reg;
        chain[0].lowest     = cmd_reg.beat.priority_req;
    end

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            pvsa_cell #(
                .CELL_POS(g)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cmd      (cmd_reg),
                .commit   (commit),
                .carry_in (chain[g]),
                .carry_out(chain[g+1])
            );
        end
    endgenerate

    always_comb begin
        result.ok             = res_reg.ok;
        result.result_slot    = 5'(NO_SLOT);
        result.result_version = 16'd0;
        result.read_value     = res_reg.rval;
        result.stole_voice    = 1'b0;
        if (cmd_reg.beat.mode == pvsa_pkg::MODE_PLAY) begin
            result.ok         = res_reg.have_pick;
            result.read_value = 16'd0;
            if (res_reg.have_pick) begin
                result.result_slot    = 5'(res_reg.pick);
                result.result_version = res_reg.pick_ver + 16'd1;
                result.stole_voice    = !res_reg.found_free;
            end
        end
    end

    assign commit.en  = (state_reg == ST_DONE) && out_free &&
                        (cmd_reg.beat.mode == pvsa_pkg::MODE_PLAY) && res_reg.have_pick;
    assign commit.idx = res_reg.pick;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            launch_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            launch_reg <= accept;
            if (m_ready && !((state_reg == ST_DONE) && out_free)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cmd_reg.beat   <= s_data;
                        cmd_reg.idx    <= idx_ext;
                        cmd_reg.idx_ok <= ({4'd0, s_data.slot_index} < 9'(SLOTS)) &&
                                          (idx_ext < NO_SLOT);
                        state_reg      <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (chain[SLOTS].valid) begin
                        res_reg   <= chain[SLOTS];
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_data_reg  <= result;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/pvsa_check.sv
// ----------------------------------------------------------------------------
// pvsa_check: port level checks for the voice slot allocator
// Watches the result beats and the input handshake of the top level.
// ----------------------------------------------------------------------------
module pvsa_check #(
    parameter int SLOTS = 16
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input pvsa_pkg::in_beat_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input pvsa_pkg::out_beat_t m_data
);

    localparam logic [4:0] NO_SLOT = 5'(SLOTS);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result beat changed while stalled.");

    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.ok |-> m_data.result_slot == NO_SLOT &&
            m_data.result_version == 16'd0 && m_data.read_value == 16'd0 &&
            !m_data.stole_voice)
        else $error("Failed operation returned nonzero fields.");

    a_steal_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.stole_voice |-> m_data.ok && m_data.result_slot != NO_SLOT)
        else $error("Steal reported without a granted slot.");

    a_read_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.read_value != 16'd0 |-> m_data.ok && !m_data.stole_voice &&
            m_data.result_version == 16'd0)
        else $error("Read value mixed with a play result.");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Input taken while a beat was in progress.");

    logic unused_s_data;
    assign unused_s_data = ^s_data;

endmodule

bind priority_voice_slot_allocator_core pvsa_check #(
    .SLOTS(SLOTS)
) u_pvsa_check (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data (s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
